@@ rtl/vec4_normalize_length_unit_macros.svh @@
//------------------------------------------------------------------------------
// vec4 normalize length unit assertion macros
// shared concurrent assertion forms
//------------------------------------------------------------------------------
`ifndef VEC4_NORMALIZE_LENGTH_UNIT_MACROS_SVH
`define VEC4_NORMALIZE_LENGTH_UNIT_MACROS_SVH

// implication checked every clock outside reset
`define VNL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// invariant checked every clock outside reset
`define VNL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

@@ rtl/vnl_pkg.sv @@
//------------------------------------------------------------------------------
// vnl_pkg
// types and constants of the vec4 normalize length unit
//------------------------------------------------------------------------------
package vnl_pkg;

  localparam int unsigned N_COMP    = 4;
  localparam int unsigned COMP_W    = 16;
  localparam int unsigned SUM_W     = 33;
  localparam int unsigned ROOT_W    = 17;
  localparam int unsigned QUO_W     = 15;
  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned DREM_W    = COMP_W + FRAC_BITS;
  localparam int unsigned ROOT_BITS = ROOT_W;
  localparam int unsigned QUO_BITS  = QUO_W;

  typedef struct packed {
    logic                               valid;
    logic [SUM_W-1:0]                   rem;
    logic [ROOT_W-1:0]                  root;
    logic [N_COMP-1:0][COMP_W-1:0]      mag;
    logic [N_COMP-1:0]                  neg;
  } sqrt_bus_t;

  typedef struct packed {
    logic                               valid;
    logic [ROOT_W-1:0]                  len;
    logic [N_COMP-1:0][DREM_W-1:0]      rem;
    logic [N_COMP-1:0][QUO_W-1:0]       quo;
    logic [N_COMP-1:0]                  neg;
  } div_bus_t;

endpackage

@@ rtl/vnl_sqrt_cell.sv @@
//------------------------------------------------------------------------------
// vnl_sqrt_cell
// one root bit of the square root chain, registered
//------------------------------------------------------------------------------
module vnl_sqrt_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vnl_pkg::sqrt_bus_t bus_i,
  output vnl_pkg::sqrt_bus_t bus_o
);
  import vnl_pkg::*;

  localparam int unsigned TW = SUM_W + 2;

  sqrt_bus_t  bus_r, bus_nxt;
  logic [TW-1:0] trial;

  always_comb begin
    trial   = ((TW'({bus_i.root, 1'b0}) + (TW'(1) << BIT)) << BIT);
    bus_nxt = bus_i;
    if (TW'(bus_i.rem) >= trial) begin
      bus_nxt.rem       = bus_i.rem - trial[SUM_W-1:0];
      bus_nxt.root[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.valid <= 1'b0;
    end else begin
      bus_r.valid <= bus_nxt.valid;
    end
    bus_r.rem  <= bus_nxt.rem;
    bus_r.root <= bus_nxt.root;
    bus_r.mag  <= bus_nxt.mag;
    bus_r.neg  <= bus_nxt.neg;
  end

  assign bus_o = bus_r;

endmodule

@@ rtl/vnl_div_cell.sv @@
//------------------------------------------------------------------------------
// vnl_div_cell
// one quotient bit for all four components, registered
//------------------------------------------------------------------------------
module vnl_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  vnl_pkg::div_bus_t bus_i,
  output vnl_pkg::div_bus_t bus_o
);
  import vnl_pkg::*;

  localparam int unsigned TW = ROOT_W + QUO_W;

  div_bus_t      bus_r, bus_nxt;
  logic [TW-1:0] dtrial;

  always_comb begin
    dtrial  = TW'(bus_i.len) << BIT;
    bus_nxt = bus_i;
    for (int i = 0; i < N_COMP; i++) begin
      if (TW'(bus_i.rem[i]) >= dtrial) begin
        bus_nxt.rem[i]      = bus_i.rem[i] - dtrial[DREM_W-1:0];
        bus_nxt.quo[i][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.valid <= 1'b0;
    end else begin
      bus_r.valid <= bus_nxt.valid;
    end
    bus_r.len <= bus_nxt.len;
    bus_r.rem <= bus_nxt.rem;
    bus_r.quo <= bus_nxt.quo;
    bus_r.neg <= bus_nxt.neg;
  end

  assign bus_o = bus_r;

endmodule

@@ rtl/vec4_normalize_length_unit.sv @@
//------------------------------------------------------------------------------
// vec4_normalize_length_unit
// length and unit vector of a signed Q8.8 4-vector
//------------------------------------------------------------------------------
// A request is taken every cycle (busy stays low) and its result leaves on the
// out_ ports with out_strobe high after passing through one input register, one
// sum register, 17 square root cells and 15 divider cells, each a register, and
// one output register. The receiver cannot stall, so results are never held;
// requests come out in the order they went in.
module vec4_normalize_length_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [vnl_pkg::COMP_W-1:0]      in_comp_x,
  input  logic signed [vnl_pkg::COMP_W-1:0]      in_comp_y,
  input  logic signed [vnl_pkg::COMP_W-1:0]      in_comp_z,
  input  logic signed [vnl_pkg::COMP_W-1:0]      in_comp_w,
  output logic                                   out_strobe,
  output logic signed [vnl_pkg::COMP_W-1:0]      out_unit_x,
  output logic signed [vnl_pkg::COMP_W-1:0]      out_unit_y,
  output logic signed [vnl_pkg::COMP_W-1:0]      out_unit_z,
  output logic signed [vnl_pkg::COMP_W-1:0]      out_unit_w,
  output logic        [vnl_pkg::ROOT_W-1:0]      out_magnitude
);
  import vnl_pkg::*;

  `include "vec4_normalize_length_unit_macros.svh"

  localparam int unsigned SQ_W = 2 * COMP_W;

  logic [N_COMP-1:0][COMP_W-1:0] comp;
  logic [N_COMP-1:0][COMP_W-1:0] mag_nxt;
  logic                          in_valid_r;
  logic [N_COMP-1:0][COMP_W-1:0] mag_r;
  logic [N_COMP-1:0]             neg_r;
  logic [N_COMP-1:0][SQ_W-1:0]   sq_r;
  sqrt_bus_t                     sq_bus_r;
  sqrt_bus_t                     sqrt_chain [ROOT_BITS+1];
  div_bus_t                      div_head;
  div_bus_t                      div_chain  [QUO_BITS+1];
  logic [N_COMP-1:0][COMP_W-1:0] unit_nxt;
  logic [N_COMP-1:0][COMP_W-1:0] unit_r;
  logic [ROOT_W-1:0]             mag_out_r;
  logic                          out_valid_r;

  assign busy = 1'b0;
  assign comp = {in_comp_w, in_comp_z, in_comp_y, in_comp_x};

  always_comb begin
    for (int i = 0; i < N_COMP; i++) begin
      mag_nxt[i] = comp[i][COMP_W-1] ? (COMP_W'(0) - comp[i]) : comp[i];
    end
  end

  // input register with squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
    for (int i = 0; i < N_COMP; i++) begin
      mag_r[i] <= mag_nxt[i];
      neg_r[i] <= comp[i][COMP_W-1];
      sq_r[i]  <= mag_nxt[i] * mag_nxt[i];
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_bus_r.valid <= 1'b0;
    end else begin
      sq_bus_r.valid <= in_valid_r;
    end
    sq_bus_r.rem  <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]) + SUM_W'(sq_r[3]);
    sq_bus_r.root <= '0;
    sq_bus_r.mag  <= mag_r;
    sq_bus_r.neg  <= neg_r;
  end

  assign sqrt_chain[0] = sq_bus_r;

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_sqrt
    vnl_sqrt_cell #(
      .BIT (ROOT_BITS - 1 - g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .bus_i (sqrt_chain[g]),
      .bus_o (sqrt_chain[g+1])
    );
  end

  always_comb begin
    div_head.valid = sqrt_chain[ROOT_BITS].valid;
    div_head.len   = sqrt_chain[ROOT_BITS].root;
    div_head.neg   = sqrt_chain[ROOT_BITS].neg;
    div_head.quo   = '0;
    for (int i = 0; i < N_COMP; i++) begin
      div_head.rem[i] = {sqrt_chain[ROOT_BITS].mag[i], FRAC_BITS'(0)};
    end
  end

  assign div_chain[0] = div_head;

  for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
    vnl_div_cell #(
      .BIT (QUO_BITS - 1 - g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .bus_i (div_chain[g]),
      .bus_o (div_chain[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i < N_COMP; i++) begin
      if (div_chain[QUO_BITS].len == '0) begin
        unit_nxt[i] = '0;
      end else if (div_chain[QUO_BITS].neg[i]) begin
        unit_nxt[i] = COMP_W'(0) - COMP_W'(div_chain[QUO_BITS].quo[i]);
      end else begin
        unit_nxt[i] = COMP_W'(div_chain[QUO_BITS].quo[i]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_chain[QUO_BITS].valid;
    end
    unit_r    <= unit_nxt;
    mag_out_r <= div_chain[QUO_BITS].len;
  end

  assign out_strobe    = out_valid_r;
  assign out_unit_x    = unit_r[0];
  assign out_unit_y    = unit_r[1];
  assign out_unit_z    = unit_r[2];
  assign out_unit_w    = unit_r[3];
  assign out_magnitude = mag_out_r;

  `VNL_ASSERT_IMP(a_zero_len_zero_unit, out_strobe && out_magnitude == '0,
    out_unit_x == '0 && out_unit_y == '0 && out_unit_z == '0 && out_unit_w == '0,
    "zero length with nonzero unit component")
  `VNL_ASSERT_IMP(a_mag_range, out_strobe,
    out_magnitude <= ROOT_W'(65536), "magnitude out of range")
  `VNL_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

endmodule
